FILE: rtl/bww_pkg.sv
// Shared widths, constants and record types of the balanced word wrapper.
`timescale 1ns / 1ps
`default_nettype none

package bww_pkg;

    // Field widths
    localparam int PIXEL_BITS = 15;
    localparam int COUNT_BITS = 16;
    localparam int WIDTH_BITS = PIXEL_BITS + 1;

    // Line width after reset
    localparam logic [PIXEL_BITS-1:0] LINE_WIDTH_RESET = PIXEL_BITS'(128);

    // Results per word and result queue sizing
    localparam int MAX_RESULTS    = 3;
    localparam int PUSH_CNT_BITS  = $clog2(MAX_RESULTS + 1);
    localparam int RES_FIFO_DEPTH = 8;
    localparam int RES_PTR_BITS   = $clog2(RES_FIFO_DEPTH);
    localparam int RES_CNT_BITS   = $clog2(RES_FIFO_DEPTH + 1);

    // One input word as measured by the front end
    typedef struct packed {
        logic [PIXEL_BITS-1:0] word_width;
        logic [PIXEL_BITS-1:0] space_width;
        logic [COUNT_BITS-1:0] char_count;
        logic                  ends_line;
        logic                  end_of_text;
    } t_item;

    // Last word kept for a line
    typedef struct packed {
        logic [PIXEL_BITS-1:0] word;
        logic [PIXEL_BITS-1:0] space;
        logic [COUNT_BITS-1:0] chars;
    } t_word_rec;

    // State of one line
    typedef struct packed {
        logic [COUNT_BITS-1:0] chars;
        logic [WIDTH_BITS-1:0] width;
        logic                  brk;
        t_word_rec             last;
        logic [PIXEL_BITS-1:0] prior_space;
    } t_line;

    // Open line and held line
    typedef struct packed {
        t_line cur;
        t_line prev;
    } t_lines;

    // One emitted line
    typedef struct packed {
        logic [COUNT_BITS-1:0] line_chars;
        logic                  last_line;
    } t_result;

    // Results produced by one word, packed from slot 0
    typedef struct packed {
        logic [PUSH_CNT_BITS-1:0]  count;
        t_result [MAX_RESULTS-1:0] res;
    } t_push;

endpackage

`default_nettype wire

FILE: rtl/bww_if.sv
// Valid/ready channel interfaces of the balanced word wrapper.
`timescale 1ns / 1ps
`default_nettype none

// Word channel
interface bww_word_if import bww_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] word_width;
    logic [PIXEL_BITS-1:0] space_width;
    logic [COUNT_BITS-1:0] char_count;
    logic                  ends_line;
    logic                  end_of_text;

    modport source (
        output valid, word_width, space_width, char_count, ends_line, end_of_text,
        input  ready
    );
    modport sink (
        input  valid, word_width, space_width, char_count, ends_line, end_of_text,
        output ready
    );
endinterface

// Line result channel
interface bww_line_if import bww_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [COUNT_BITS-1:0] line_chars;
    logic                  last_line;

    modport source (
        output valid, line_chars, last_line,
        input  ready
    );
    modport sink (
        input  valid, line_chars, last_line,
        output ready
    );
endinterface

// Line width register write channel
interface bww_cfg_if import bww_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] line_width;

    modport source (
        output valid, line_width,
        input  ready
    );
    modport sink (
        input  valid, line_width,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/balanced_word_wrap.sv
// Top level of the balanced word wrapper.
// Takes one measured word per transfer and returns the character count of each
// finished line, balancing the last two lines by moving one word when that lowers
// the summed squared slack. A word transfer is held in an input register, then the
// whole line update (fit check, one balance step with four 20-bit squares, word
// append, break and flush) runs on it. Each word yields zero to three lines, which
// go to an 8-entry result queue that hands out one line per cycle while ready is
// high; a word waits in the input register while the queue has fewer than three
// free entries, so the input runs at one word per cycle whenever the output keeps
// up with the lines produced. The line width register resets to 128 and takes a
// write in any cycle; write it only while no text is in flight.
`timescale 1ns / 1ps
`default_nettype none

module balanced_word_wrap import bww_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bww_word_if.sink     i_word,
    bww_cfg_if.sink      i_cfg,
    bww_line_if.source   o_line
);

    logic [PIXEL_BITS-1:0] r_line_width;
    logic                  r_in_valid;
    t_item                 r_item;
    t_lines                r_lines;
    t_lines                n_lines;
    t_push                 push;
    logic                  room;
    logic                  proc;

    // Line width register
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
        end else if (i_cfg.valid) begin
            r_line_width <= i_cfg.line_width;
        end
    end

    // Process the held word when the queue has room
    assign proc         = r_in_valid && room;
    assign i_word.ready = !r_in_valid || proc;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_word.ready) begin
            r_in_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_word.valid && i_word.ready) begin
            r_item.word_width  <= i_word.word_width;
            r_item.space_width <= i_word.space_width;
            r_item.char_count  <= i_word.char_count;
            r_item.ends_line   <= i_word.ends_line;
            r_item.end_of_text <= i_word.end_of_text;
        end
    end

    // Line state update
    bww_step u_step (
        .i_state      (r_lines),
        .i_item       (r_item),
        .i_line_width (r_line_width),
        .o_state      (n_lines),
        .o_push       (push)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lines <= '0;
        end else if (proc) begin
            r_lines <= n_lines;
        end
    end

    // Result queue
    bww_res_fifo u_res_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (proc),
        .i_push    (push),
        .o_room    (room),
        .o_line    (o_line)
    );

endmodule

`default_nettype wire

FILE: rtl/bww_step.sv
// Next line state and emitted lines for one word.
`timescale 1ns / 1ps
`default_nettype none

module bww_step import bww_pkg::*; (
    input  var t_lines                i_state,
    input  var t_item                 i_item,
    input  var logic [PIXEL_BITS-1:0] i_line_width,
    output t_lines                    o_state,
    output t_push                     o_push
);

    localparam int DIFF_BITS = WIDTH_BITS + 4;
    localparam int SQ_BITS   = 2 * DIFF_BITS;
    localparam int SUM_BITS  = WIDTH_BITS + 2;
    localparam int N_CAND    = MAX_RESULTS + 1;

    // Zero-extend a width into the signed slack domain
    function automatic logic signed [DIFF_BITS-1:0] zx(input logic [WIDTH_BITS-1:0] v);
        return $signed({{(DIFF_BITS - WIDTH_BITS){1'b0}}, v});
    endfunction

    // Clamp a grown width at the top of the width range
    function automatic logic [WIDTH_BITS-1:0] sat(input logic [SUM_BITS-1:0] v);
        if (v > {2'b00, {WIDTH_BITS{1'b1}}}) begin
            return {WIDTH_BITS{1'b1}};
        end
        return v[WIDTH_BITS-1:0];
    endfunction

    logic signed [DIFF_BITS-1:0] lws, cw1, pw1, cw2, pw2;
    logic signed [DIFF_BITS-1:0] e_p1, e_c1, e_p2, e_c2;
    logic signed [SQ_BITS-1:0]   q_p1, q_c1, q_p2, q_c2;
    logic signed [SQ_BITS:0]     d1, d2;
    logic                        better;

    // Slack of both lines before and after moving the held line's last word
    always_comb begin
        lws  = zx(WIDTH_BITS'(i_line_width));
        cw1  = zx(i_state.cur.width) - zx(WIDTH_BITS'(i_state.cur.last.space));
        pw1  = zx(i_state.prev.width) - zx(WIDTH_BITS'(i_state.prev.last.space));
        cw2  = zx(i_state.cur.width) + zx(WIDTH_BITS'(i_state.prev.last.word));
        pw2  = zx(i_state.prev.width) - zx(WIDTH_BITS'(i_state.prev.last.word))
             - zx(WIDTH_BITS'(i_state.prev.last.space))
             - zx(WIDTH_BITS'(i_state.prev.prior_space));
        e_p1 = lws - pw1;
        e_c1 = lws - cw1;
        e_p2 = lws - pw2;
        e_c2 = lws - cw2;
        q_p1 = e_p1 * e_p1;
        q_c1 = e_c1 * e_c1;
        q_p2 = e_p2 * e_p2;
        q_c2 = e_c2 * e_c2;
        d1   = {q_p1[SQ_BITS-1], q_p1} + {q_c1[SQ_BITS-1], q_c1};
        d2   = {q_p2[SQ_BITS-1], q_p2} + {q_c2[SQ_BITS-1], q_c2};
        better = (d1 > d2) && (cw2 <= lws);
    end

    logic                        empty, fin1, mv;
    logic [WIDTH_BITS:0]         fit_sum;
    logic [WIDTH_BITS:0]         moved;
    t_lines                      a, b, f;
    logic [N_CAND-1:0]           cand_v;
    logic [COUNT_BITS-1:0]       cand_val [N_CAND];
    logic [PUSH_CNT_BITS-1:0]    k;

    // Wrap, place the word, break and flush
    always_comb begin
        // Close the open line when the word does not fit
        empty   = (i_state.cur.chars == '0) && (i_state.cur.width == '0);
        fit_sum = {1'b0, i_state.cur.width}
                + {{(WIDTH_BITS + 1 - PIXEL_BITS){1'b0}}, i_item.word_width};
        fin1    = (fit_sum > {{(WIDTH_BITS + 1 - PIXEL_BITS){1'b0}}, i_line_width}) && !empty;
        cand_v[0]   = fin1 && (i_state.prev.chars != '0);
        mv          = cand_v[0] && !i_state.prev.brk && !i_state.cur.brk && better;
        cand_val[0] = mv ? i_state.prev.chars - i_state.prev.last.chars : i_state.prev.chars;
        moved   = {1'b0, WIDTH_BITS'(i_state.prev.last.word)}
                + {1'b0, WIDTH_BITS'(i_state.prev.last.space)};

        a = i_state;
        if (fin1) begin
            a.prev = i_state.cur;
            if (mv) begin
                a.prev.chars = i_state.cur.chars + i_state.prev.last.chars;
                a.prev.width = sat({2'b00, i_state.cur.width} + {1'b0, moved});
            end
            a.cur = '0;
        end

        // Append the word to the open line
        b = a;
        b.cur.prior_space = a.cur.last.space;
        b.cur.last.word   = i_item.word_width;
        b.cur.last.space  = i_item.space_width;
        b.cur.last.chars  = i_item.char_count;
        b.cur.brk         = i_item.ends_line;
        b.cur.chars       = a.cur.chars + i_item.char_count;
        b.cur.width       = sat({2'b00, a.cur.width}
                               + {{(SUM_BITS - PIXEL_BITS){1'b0}}, i_item.word_width}
                               + {{(SUM_BITS - PIXEL_BITS){1'b0}}, i_item.space_width});

        // Forced break: emit the held line, hold the open one
        cand_v[1]   = i_item.ends_line && (a.prev.chars != '0);
        cand_val[1] = a.prev.chars;
        f = b;
        if (i_item.ends_line) begin
            f.prev = b.cur;
            f.cur  = '0;
        end

        // End of text: flush both lines and clear
        cand_v[2]   = i_item.end_of_text && (f.prev.chars != '0);
        cand_val[2] = f.prev.chars;
        cand_v[3]   = i_item.end_of_text && (f.cur.chars != '0);
        cand_val[3] = f.cur.chars;
        o_state = i_item.end_of_text ? '0 : f;

        // Pack the emitted lines in order
        k = '0;
        o_push = '0;
        for (int i = 0; i < N_CAND; i++) begin
            if (cand_v[i]) begin
                if (k < PUSH_CNT_BITS'(MAX_RESULTS)) begin
                    o_push.res[k].line_chars = cand_val[i];
                end
                k = k + PUSH_CNT_BITS'(1);
            end
        end
        if (i_item.end_of_text && (k != '0)) begin
            o_push.res[k - PUSH_CNT_BITS'(1)].last_line = 1'b1;
        end
        o_push.count = k;
    end

endmodule

`default_nettype wire

FILE: rtl/bww_res_fifo.sv
// Result queue: takes up to three lines a cycle, hands out one a cycle while the receiver is ready.
`timescale 1ns / 1ps
`default_nettype none

module bww_res_fifo import bww_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push_en,
    input  var t_push          i_push,
    output logic               o_room,
    bww_line_if.source         o_line
);

    t_result                  r_mem [RES_FIFO_DEPTH];
    logic [RES_PTR_BITS-1:0]  r_wr, r_rd;
    logic [RES_CNT_BITS-1:0]  r_count;
    logic [PUSH_CNT_BITS-1:0] push_n;
    logic                     pop;

    assign push_n = i_push_en ? i_push.count : '0;
    assign pop    = o_line.valid && o_line.ready;

    // Room for a full set of results from one word
    assign o_room = r_count <= RES_CNT_BITS'(RES_FIFO_DEPTH - MAX_RESULTS);

    // Write the new lines in order
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_RESULTS; j++) begin
            if (PUSH_CNT_BITS'(j) < push_n) begin
                r_mem[r_wr + RES_PTR_BITS'(j)] <= i_push.res[j];
            end
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + RES_PTR_BITS'(push_n);
            r_rd    <= r_rd + RES_PTR_BITS'(pop);
            r_count <= r_count + RES_CNT_BITS'(push_n) - RES_CNT_BITS'(pop);
        end
    end

    // Present the oldest line
    assign o_line.valid      = r_count != '0;
    assign o_line.line_chars = r_mem[r_rd].line_chars;
    assign o_line.last_line  = r_mem[r_rd].last_line;

endmodule

`default_nettype wire

FILE: tb/sv/bww_wrap_check.sv
// Line prediction and result checking for the balanced word wrapper testbench.
`timescale 1ns / 1ps

module bww_wrap_check import bww_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bww_word_if  i_word,
    bww_cfg_if   i_cfg,
    bww_line_if  i_line,
    output int   o_fail_count,
    output int   o_pending
);

    localparam longint WIDTH_TOP = (longint'(1) << WIDTH_BITS) - 1;

    logic [PIXEL_BITS-1:0] line_width;
    t_line                 open_line;
    t_line                 held_line;
    t_result               line_q[$];

    // Hold a line width inside 0 .. 2^WIDTH_BITS-1
    function automatic logic [WIDTH_BITS-1:0] clamp_width(input longint v);
        if (v < 0) return '0;
        if (v > WIDTH_TOP) return '1;
        return WIDTH_BITS'(v);
    endfunction

    function automatic longint sqr(input longint x);
        return x * x;
    endfunction

    // Queue one expected line, not yet marked as the last one
    function automatic void push_line(input logic [COUNT_BITS-1:0] chars);
        t_result r;
        r.line_chars = chars;
        r.last_line  = 1'b0;
        line_q.push_back(r);
    endfunction

    // Finish the open line: balance against the held line, emit the held line, shift down
    function automatic void close_line();
        longint lw, cw1, pw1, cw2, pw2, d1, d2, moved;
        if (held_line.chars != 0) begin
            if (!held_line.brk && !open_line.brk) begin
                lw    = longint'(line_width);
                cw1   = longint'(open_line.width) - longint'(open_line.last.space);
                pw1   = longint'(held_line.width) - longint'(held_line.last.space);
                d1    = sqr(lw - pw1) + sqr(lw - cw1);
                cw2   = longint'(open_line.width) + longint'(held_line.last.word);
                pw2   = longint'(held_line.width) - longint'(held_line.last.word)
                      - longint'(held_line.last.space) - longint'(held_line.prior_space);
                d2    = sqr(lw - pw2) + sqr(lw - cw2);
                moved = longint'(held_line.last.word) + longint'(held_line.last.space);
                // Move the word down only if the slack drops and it still fits
                if (d1 > d2 && cw2 <= lw) begin
                    held_line.chars      = held_line.chars - held_line.last.chars;
                    open_line.chars      = open_line.chars + held_line.last.chars;
                    held_line.width      = clamp_width(longint'(held_line.width) - moved);
                    open_line.width      = clamp_width(longint'(open_line.width) + moved);
                    held_line.last.word  = '0;
                    held_line.last.space = held_line.prior_space;
                    held_line.last.chars = '0;
                end
            end
            push_line(held_line.chars);
        end
        held_line = open_line;
        open_line = '0;
    endfunction

    // Work out the lines that one word transfer produces
    function automatic void wrap_word(input t_item it);
        int      base;
        logic    empty;
        t_result tail;
        base  = line_q.size();
        empty = (open_line.chars == 0) && (open_line.width == 0);
        if (int'(open_line.width) + int'(it.word_width) > int'(line_width) && !empty)
            close_line();
        open_line.prior_space = open_line.last.space;
        open_line.last.word   = it.word_width;
        open_line.last.space  = it.space_width;
        open_line.last.chars  = it.char_count;
        open_line.brk         = it.ends_line;
        open_line.chars       = open_line.chars + it.char_count;
        open_line.width       = clamp_width(longint'(open_line.width)
                              + longint'(it.word_width) + longint'(it.space_width));
        if (open_line.brk) close_line();
        // Flush both lines at end of text and mark the final one
        if (it.end_of_text) begin
            if (held_line.chars != 0) push_line(held_line.chars);
            if (open_line.chars != 0) push_line(open_line.chars);
            if (line_q.size() > base) begin
                tail = line_q.pop_back();
                tail.last_line = 1'b1;
                line_q.push_back(tail);
            end
            held_line = '0;
            open_line = '0;
        end
    endfunction

    // Track register writes and word transfers, compare each line transfer
    always @(posedge i_clk) begin : watch
        t_item   word_in;
        t_result want;
        if (!i_rst_n) begin
            line_width   = LINE_WIDTH_RESET;
            open_line    = '0;
            held_line    = '0;
            line_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) line_width = i_cfg.line_width;
            if (i_word.valid && i_word.ready) begin
                word_in.word_width  = i_word.word_width;
                word_in.space_width = i_word.space_width;
                word_in.char_count  = i_word.char_count;
                word_in.ends_line   = i_word.ends_line;
                word_in.end_of_text = i_word.end_of_text;
                wrap_word(word_in);
            end
            if (i_line.valid && i_line.ready) begin
                if (line_q.size() == 0) begin
                    $error("line_chars: no line expected, got %0d (last_line %0b)",
                           i_line.line_chars, i_line.last_line);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = line_q.pop_front();
                    if (want.line_chars !== i_line.line_chars) begin
                        $error("line_chars: expected %0d, got %0d",
                               want.line_chars, i_line.line_chars);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (want.last_line !== i_line.last_line) begin
                        $error("last_line: expected %0b, got %0b",
                               want.last_line, i_line.last_line);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
        end
        o_pending = line_q.size();
    end

endmodule

FILE: tb/sv/tb.sv
// Top of the balanced word wrapper testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import bww_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int PHASE_ITEMS   = 75;

    logic clk;
    logic rst_n;
    int   snd_idle_pct;
    int   rcv_idle_pct;
    int   rcv_hold;
    int   quiet_cycles = 0;
    int   fail_count;
    int   pending;

    bww_word_if word_ch ();
    bww_cfg_if  cfg_ch ();
    bww_line_if line_ch ();

    balanced_word_wrap uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_word  (word_ch),
        .i_cfg   (cfg_ch),
        .o_line  (line_ch)
    );

    bww_wrap_check wrap_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_word       (word_ch),
        .i_cfg        (cfg_ch),
        .i_line       (line_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Count cycles without any transfer
    always @(posedge clk) begin
        if ((word_ch.valid && word_ch.ready) || (line_ch.valid && line_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stop a hung run
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("** balanced_word_wrap: FAILED **");
        $finish;
    end

    // Drive line ready: random stalls, or a long hold-off when requested
    initial begin
        line_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (rcv_hold > 0) begin
                line_ch.ready <= 1'b0;
                rcv_hold = rcv_hold - 1;
            end else begin
                line_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
            end
        end
    end

    function automatic t_item word_item(input int w, input int s, input int c,
                                        input bit el, input bit eot);
        t_item it;
        it.word_width  = PIXEL_BITS'(w);
        it.space_width = PIXEL_BITS'(s);
        it.char_count  = COUNT_BITS'(c);
        it.ends_line   = el;
        it.end_of_text = eot;
        return it;
    endfunction

    // Mostly plain text scaled to the line width, some raw noise
    function automatic t_item make_word(input int lw, input bit last);
        t_item it;
        int    wmax;
        wmax = lw / 4 + 2;
        if ($urandom_range(99) < 10) begin
            it.word_width  = PIXEL_BITS'($urandom);
            it.space_width = PIXEL_BITS'($urandom);
            it.char_count  = COUNT_BITS'($urandom);
            it.ends_line   = 1'($urandom);
            it.end_of_text = ($urandom_range(3) == 0);
        end else begin
            it.word_width  = PIXEL_BITS'($urandom_range(wmax, 0));
            it.space_width = PIXEL_BITS'($urandom_range(wmax / 4 + 1, 0));
            it.char_count  = COUNT_BITS'($urandom_range(12, 1));
            it.ends_line   = ($urandom_range(99) < 8);
            it.end_of_text = ($urandom_range(99) < 2);
        end
        if (last) it.end_of_text = 1'b1;
        return it;
    endfunction

    // Offer one word after a random gap and hold it until the transfer
    task automatic send_word(input t_item it);
        while ($urandom_range(99) < snd_idle_pct) begin
            word_ch.valid <= 1'b0;
            @(negedge clk);
        end
        word_ch.valid       <= 1'b1;
        word_ch.word_width  <= it.word_width;
        word_ch.space_width <= it.space_width;
        word_ch.char_count  <= it.char_count;
        word_ch.ends_line   <= it.ends_line;
        word_ch.end_of_text <= it.end_of_text;
        do @(posedge clk); while (!word_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_line_width(input logic [PIXEL_BITS-1:0] v);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.line_width <= v;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop offering words until every expected line is back, then let the block settle
    task automatic drain_lines();
        word_ch.valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial begin : stimulus
        int p;
        int k;
        int lw;
        rst_n               = 1'b0;
        word_ch.valid       = 1'b0;
        word_ch.word_width  = '0;
        word_ch.space_width = '0;
        word_ch.char_count  = '0;
        word_ch.ends_line   = 1'b0;
        word_ch.end_of_text = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.line_width   = '0;
        snd_idle_pct        = 21;
        rcv_idle_pct        = 57;
        rcv_hold            = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset width 128: a balancing move, an oversized word, forced break,
        // count wrap, empty lines, maximal fields and the end-of-text flushes
        send_word(word_item(100, 4, 5, 0, 0));
        send_word(word_item(20, 4, 3, 0, 0));
        send_word(word_item(10, 4, 2, 0, 0));
        send_word(word_item(200, 4, 6, 0, 0));
        send_word(word_item(30, 2, 4, 1, 0));
        send_word(word_item(0, 0, 65535, 0, 0));
        send_word(word_item(0, 0, 65535, 0, 0));
        send_word(word_item(0, 0, 0, 1, 0));
        send_word(word_item(0, 0, 0, 1, 0));
        send_word(word_item(32767, 32767, 65535, 0, 0));
        send_word(word_item(5, 1, 2, 0, 1));
        send_word(word_item(0, 0, 0, 0, 1));
        send_word(word_item(7, 1, 3, 1, 1));
        drain_lines();

        // Widest lines: line width saturates
        write_line_width(PIXEL_BITS'(32767));
        send_word(word_item(0, 32767, 1, 0, 0));
        send_word(word_item(0, 32767, 1, 0, 0));
        send_word(word_item(0, 32767, 1, 0, 0));
        send_word(word_item(32767, 0, 1, 0, 1));
        drain_lines();

        // Zero width: a word fits only if it and the open line both have zero width
        write_line_width('0);
        send_word(word_item(0, 0, 1, 0, 0));
        send_word(word_item(0, 5, 1, 0, 0));
        send_word(word_item(1, 0, 1, 0, 0));
        send_word(word_item(0, 0, 1, 1, 0));
        send_word(word_item(3, 0, 2, 0, 1));
        drain_lines();

        // Random text over several line widths and idle patterns
        for (p = 0; p < 6; p++) begin
            case (p)
                0:       lw = 64;
                1:       lw = 1;
                2:       lw = 200;
                3:       lw = 32767;
                4:       lw = $urandom_range(32767, 1);
                default: lw = 100;
            endcase
            if (p < 2) begin
                snd_idle_pct = 21;
                rcv_idle_pct = 57;
            end else if (p < 4) begin
                snd_idle_pct = 57;
                rcv_idle_pct = 21;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            write_line_width(PIXEL_BITS'(lw));
            for (k = 0; k < PHASE_ITEMS; k++) begin
                // Fill the block against a stalled receiver
                if (p == 0 && k == 30) rcv_hold = HOLD_CYCLES;
                if (p == 2 && k == 40) drain_lines();
                send_word(make_word(lw, k == PHASE_ITEMS - 1));
            end
            drain_lines();
        end

        if (fail_count == 0 && pending == 0)
            $display("** balanced_word_wrap: PASSED **");
        else
            $display("** balanced_word_wrap: FAILED **");
        $finish;
    end

endmodule
